### sv/hex_dump_formatter_assert.svh
// Assertion macros for the hex dump formatter.
// Included by files that check internal invariants; needs clk and rst_n in scope.
`ifndef HEX_DUMP_FORMATTER_ASSERT_SVH
`define HEX_DUMP_FORMATTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define HDF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hex dump formatter check failed");

// Next-cycle implication, disabled in reset.
`define HDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hex dump formatter check failed");

`endif

### sv/hdf_pkg.sv
// Shared constants, types and character helpers for the hex dump formatter.
// No dependencies.
`timescale 1ns / 1ps

package hdf_pkg;

    localparam int BYTES_PER_LINE = 16;
    localparam int OFFSET_DIGITS  = 8;
    localparam int OFFSET_W       = 32;
    localparam int OFFSET_NIBBLES = OFFSET_W / 4;

    localparam int ADDR_W = $clog2(BYTES_PER_LINE);
    localparam int CNT_W  = $clog2(BYTES_PER_LINE + 1);
    localparam int PAD_W  = $clog2(3 * BYTES_PER_LINE + 1);
    localparam int DIG_W  = $clog2(OFFSET_DIGITS);

    localparam logic [6:0] CH_SPACE   = 7'h20;
    localparam logic [6:0] CH_COLON   = 7'h3a;
    localparam logic [6:0] CH_DOT     = 7'h2e;
    localparam logic [6:0] CH_NEWLINE = 7'h0a;
    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd126;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // One line run handed from the input side to the emitter.
    typedef struct packed {
        logic              has_bytes;   // data beat: hex digits follow
        logic              start_line;  // offset prefix first
        logic              close;       // line ends after this run
        logic [7:0]        byte_val;
        logic [CNT_W-1:0]  cnt;         // bytes on the line at close
        logic [PAD_W-1:0]  pad;         // padding spaces before separator
    } job_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10)
            c = CH_ZERO + {3'b000, nib};
        else
            c = CH_LOWER_A + {3'b000, nib - 4'd10};
        return c;
    endfunction

    function automatic logic [3:0] offset_nibble(input logic [OFFSET_W-1:0] off,
                                                 input logic [DIG_W-1:0]    place);
        logic [OFFSET_W-1:0] sh;
        sh = off >> {place, 2'b00};
        return (32'(place) < OFFSET_NIBBLES) ? sh[3:0] : 4'd0;
    endfunction

    function automatic logic [6:0] printable_char(input logic [7:0] b);
        return (b >= PRINT_LO && b <= PRINT_HI) ? b[6:0] : CH_DOT;
    endfunction

endpackage

### sv/hdf_line_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module hdf_line_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/hdf_emit.sv
// Character sequencer: walks one run and drives the registered output beat.
// Depends on hdf_pkg; reads the line RAM through rd_addr / rd_data.
`timescale 1ns / 1ps

module hdf_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    input  hdf_pkg::job_t               job,
    input  logic [hdf_pkg::OFFSET_W-1:0] offset,
    output logic                        busy,
    output logic [hdf_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [7:0]                  rd_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [6:0]                  text_char,
    output logic                        last_of_run
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OFFSET,
        ST_COLON,
        ST_OSPACE,
        ST_HEXHI,
        ST_HEXLO,
        ST_HSPACE,
        ST_PAD,
        ST_SEP,
        ST_PRINT,
        ST_NEWLINE
    } state_t;

    state_t                      state_reg, state_next;
    hdf_pkg::job_t               job_reg, job_next;
    logic [hdf_pkg::DIG_W-1:0]   dig_reg, dig_next;
    logic [hdf_pkg::PAD_W-1:0]   pad_reg, pad_next;
    logic [hdf_pkg::ADDR_W-1:0]  j_reg, j_next;
    logic                        out_valid_reg, out_valid_next;
    logic [6:0]                  char_reg, char_next;
    logic                        last_reg, last_next;
    logic                        emit;
    logic [6:0]                  ch;
    logic                        fin;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        dig_next       = dig_reg;
        pad_next       = pad_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        ch             = hdf_pkg::CH_SPACE;
        fin            = 1'b0;
        emit           = (state_reg != ST_IDLE) && (!out_valid_reg || out_ready);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next = job;
                    dig_next = hdf_pkg::DIG_W'(hdf_pkg::OFFSET_DIGITS - 1);
                    pad_next = job.pad;
                    j_next   = '0;
                    if (job.has_bytes)
                        state_next = job.start_line ? ST_OFFSET : ST_HEXHI;
                    else
                        state_next = (job.pad != '0) ? ST_PAD : ST_SEP;
                end
            end
            ST_OFFSET:
            begin
                ch = hdf_pkg::hex_char(hdf_pkg::offset_nibble(offset, dig_reg));
                if (emit)
                begin
                    dig_next = dig_reg - 1'b1;
                    if (dig_reg == '0)
                        state_next = ST_COLON;
                end
            end
            ST_COLON:
            begin
                ch = hdf_pkg::CH_COLON;
                if (emit)
                    state_next = ST_OSPACE;
            end
            ST_OSPACE:
            begin
                if (emit)
                    state_next = ST_HEXHI;
            end
            ST_HEXHI:
            begin
                ch = hdf_pkg::hex_char(job_reg.byte_val[7:4]);
                if (emit)
                    state_next = ST_HEXLO;
            end
            ST_HEXLO:
            begin
                ch = hdf_pkg::hex_char(job_reg.byte_val[3:0]);
                if (emit)
                    state_next = ST_HSPACE;
            end
            ST_HSPACE:
            begin
                fin = !job_reg.close;
                if (emit)
                    state_next = job_reg.close ? ST_SEP : ST_IDLE;
            end
            ST_PAD:
            begin
                if (emit)
                begin
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == hdf_pkg::PAD_W'(1))
                        state_next = ST_SEP;
                end
            end
            ST_SEP:
            begin
                if (emit)
                    state_next = ST_PRINT;
            end
            ST_PRINT:
            begin
                // rd_data holds the entry at j_reg: the RAM is addressed by j_next
                if (hdf_pkg::CNT_W'(j_reg) < job_reg.cnt)
                    ch = hdf_pkg::printable_char(rd_data);
                if (emit)
                begin
                    if (j_reg == hdf_pkg::ADDR_W'(hdf_pkg::BYTES_PER_LINE - 1))
                        state_next = ST_NEWLINE;
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            ST_NEWLINE:
            begin
                ch  = hdf_pkg::CH_NEWLINE;
                fin = 1'b1;
                if (emit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            char_next      = ch;
            last_next      = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= '0;
            dig_reg       <= '0;
            pad_reg       <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            dig_reg       <= dig_next;
            pad_reg       <= pad_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign rd_addr     = j_next;
    assign out_valid   = out_valid_reg;
    assign text_char   = char_reg;
    assign last_of_run = last_reg;

endmodule

### sv/hex_dump_formatter.sv
// Top level of the hex dump formatter: input beat decode, line state, line RAM.
// Depends on hdf_pkg, hdf_line_ram, hdf_emit and hex_dump_formatter_assert.svh.
`timescale 1ns / 1ps
//
//  channel | signals                          | beat
//  --------+----------------------------------+---------------------------------
//  in      | in_valid in_ready cmd data_byte  | one byte, or end of stream
//  out     | out_valid out_ready text_char    | one ASCII character of the dump
//          | last_of_run                      |
//
//  One character leaves per cycle during a run while out_ready is high. An input
//  beat is accepted, then yields its characters: 3 mid-line, 13 on the first
//  byte of a line, 21 on the byte that fills a line, up to 63 on a flush.
//  An end beat on an empty line produces nothing. The character sequencer
//  sets the rate; in_ready is high only while it is idle, but the last
//  character of a run may still sit in the output register.
//  Reset clears the offset, fill count and sequencer; the line RAM is not
//  cleared, since each entry is written on a line before it is shown.
//  Stalls on out_ready freeze the sequencer and hold the output beat.

module hex_dump_formatter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] text_char,
    output logic       last_of_run
);

    `include "hex_dump_formatter_assert.svh"

    logic [hdf_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic [hdf_pkg::ADDR_W-1:0]   fill_reg, fill_next;

    logic                         accept;
    logic                         line_full;
    logic                         job_valid;
    hdf_pkg::job_t                job;
    logic [hdf_pkg::PAD_W-1:0]    slots;
    logic                         busy;
    logic [hdf_pkg::ADDR_W-1:0]   rd_addr;
    logic [7:0]                   rd_data;

    assign in_ready  = !busy;
    assign accept    = in_valid && in_ready;
    assign line_full = (fill_reg == hdf_pkg::ADDR_W'(hdf_pkg::BYTES_PER_LINE - 1));

    // Padding: three spaces per empty slot, only on a flush.
    assign slots = hdf_pkg::PAD_W'(hdf_pkg::BYTES_PER_LINE) - hdf_pkg::PAD_W'(fill_reg);

    always_comb
    begin
        job            = '0;
        job.byte_val   = data_byte;
        job.has_bytes  = (cmd == hdf_pkg::CMD_DATA);
        job.start_line = (fill_reg == '0);
        job_valid      = 1'b0;
        offset_next    = offset_reg;
        fill_next      = fill_reg;

        if (cmd == hdf_pkg::CMD_DATA)
        begin
            job.close = line_full;
            job.cnt   = hdf_pkg::CNT_W'(fill_reg) + 1'b1;
            job.pad   = '0;
        end
        else
        begin
            job.close = 1'b1;
            job.cnt   = hdf_pkg::CNT_W'(fill_reg);
            job.pad   = (slots << 1) + slots;
        end

        if (accept)
        begin
            if (cmd == hdf_pkg::CMD_DATA)
            begin
                job_valid = 1'b1;
                if (line_full)
                begin
                    // offset is shown only at a line start, never in this run
                    fill_next   = '0;
                    offset_next = offset_reg + hdf_pkg::OFFSET_W'(hdf_pkg::BYTES_PER_LINE);
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            else
            begin
                job_valid   = (fill_reg != '0);
                fill_next   = '0;
                offset_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
            fill_reg   <= fill_next;
        end
    end

    // Writes land at accept; reads of a line come only in the later print states,
    // and the read port samples every cycle, so no bypass is needed.
    hdf_line_ram #(
        .DEPTH  (hdf_pkg::BYTES_PER_LINE),
        .DATA_W (8),
        .ADDR_W (hdf_pkg::ADDR_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (accept && (cmd == hdf_pkg::CMD_DATA)),
        .wr_addr (fill_reg),
        .wr_data (data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hdf_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (job),
        .offset      (offset_reg),
        .busy        (busy),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .text_char   (text_char),
        .last_of_run (last_of_run)
    );

    // An end beat on an empty line starts no run.
    `HDF_ASSERT_NEXT(a_empty_flush_idle, accept && cmd == hdf_pkg::CMD_END && fill_reg == '0, in_ready)
    // A flush returns the stream to offset zero at a line start.
    `HDF_ASSERT_NEXT(a_flush_resets, accept && cmd == hdf_pkg::CMD_END, offset_reg == '0 && fill_reg == '0)
    // A data beat always starts a run of characters.
    `HDF_ASSERT_NEXT(a_data_runs, accept && cmd == hdf_pkg::CMD_DATA, busy)

endmodule
